// ----- design/ptd_pkg.sv -----
// Shared types, widths and helper functions for the point-to-triangle distance block.
// Depends on nothing; every other file of the block imports it.

package ptd_pkg;

   localparam int CW    = 12;
   localparam int EW    = 13;
   localparam int PW    = 28;
   localparam int MW    = 56;
   localparam int SW    = 58;
   localparam int XW    = 60;
   localparam int DIVW  = 58;
   localparam int FW    = 16;
   localparam int QW    = 17;
   localparam int BW    = 48;
   localparam int UW    = 48;
   localparam int LW    = 64;
   localparam int DISTW = 42;

   localparam logic [QW-1:0]    QONE     = QW'(1) << FW;
   localparam logic [DISTW-1:0] DIST_MAX = '1;

   typedef enum logic [2:0] {
      KIND_V0,
      KIND_V1,
      KIND_V2,
      KIND_EA,
      KIND_EB,
      KIND_IN,
      KIND_SA,
      KIND_TB
   } ptd_kind_type;

   typedef struct packed {
      logic signed [PW-1:0] a;
      logic signed [PW-1:0] b;
      logic signed [PW-1:0] c;
      logic signed [PW-1:0] d;
      logic signed [PW-1:0] e;
      logic signed [PW-1:0] f;
   } ptd_dots_type;

   typedef struct packed {
      ptd_kind_type kind;
      ptd_dots_type dots;
   } ptd_side_type;

   typedef struct packed {
      logic            zero;
      logic            one;
      logic [DIVW-1:0] den;
      logic [DIVW-1:0] rem;
      logic [FW-1:0]   quo;
   } ptd_lane_type;

   function automatic ptd_lane_type ptd_div_step(input ptd_lane_type cur);
      ptd_lane_type  nxt;
      logic [DIVW:0] shifted;
      logic [DIVW:0] diff;
      nxt     = cur;
      shifted = {cur.rem, 1'b0};
      diff    = shifted - {1'b0, cur.den};
      if (shifted >= {1'b0, cur.den}) begin
         nxt.rem = diff[DIVW-1:0];
         nxt.quo = {cur.quo[FW-2:0], 1'b1};
      end else begin
         nxt.rem = shifted[DIVW-1:0];
         nxt.quo = {cur.quo[FW-2:0], 1'b0};
      end
      return nxt;
   endfunction

   function automatic logic [QW-1:0] ptd_div_result(input ptd_lane_type cur);
      logic [QW-1:0] res;
      if (cur.zero) begin
         res = '0;
      end else if (cur.one) begin
         res = QONE;
      end else begin
         res = {1'b0, cur.quo};
      end
      return res;
   endfunction

endpackage

// ----- design/ptd_if.sv -----
// Valid/ready channel interfaces for the query beat and the result beat.
// Depends on ptd_pkg for the field widths.

interface ptd_req_if import ptd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] point_x;
   logic signed [CW-1:0] point_y;
   logic signed [CW-1:0] point_z;
   logic signed [CW-1:0] corner_x;
   logic signed [CW-1:0] corner_y;
   logic signed [CW-1:0] corner_z;
   logic signed [EW-1:0] edge_a_x;
   logic signed [EW-1:0] edge_a_y;
   logic signed [EW-1:0] edge_a_z;
   logic signed [EW-1:0] edge_b_x;
   logic signed [EW-1:0] edge_b_y;
   logic signed [EW-1:0] edge_b_z;

   modport source (output valid, point_x, point_y, point_z, corner_x, corner_y, corner_z,
                   edge_a_x, edge_a_y, edge_a_z, edge_b_x, edge_b_y, edge_b_z,
                   input ready);
   modport sink (input valid, point_x, point_y, point_z, corner_x, corner_y, corner_z,
                 edge_a_x, edge_a_y, edge_a_z, edge_b_x, edge_b_y, edge_b_z,
                 output ready);
endinterface

interface ptd_rsp_if import ptd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [DISTW-1:0] dist_sq;
   logic [QW-1:0]    weight_first;
   logic [QW-1:0]    weight_second;
   logic [QW-1:0]    weight_third;

   modport source (output valid, dist_sq, weight_first, weight_second, weight_third,
                   input ready);
   modport sink (input valid, dist_sq, weight_first, weight_second, weight_third,
                 output ready);
endinterface

// ----- design/ptd_qdiv.sv -----
// Two-lane pipelined restoring divider giving Q.16 quotients, one quotient bit per stage.
// Depends on ptd_pkg for the lane and side-payload types.

module ptd_qdiv import ptd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  ptd_lane_type  in_lane0,
   input  ptd_lane_type  in_lane1,
   input  ptd_side_type  in_side,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [QW-1:0] out_q0,
   output logic [QW-1:0] out_q1,
   output ptd_side_type  out_side
);

   logic [FW-1:0] valid_ff;
   logic [FW-1:0] valid_in;
   logic [FW-1:0] adv;
   ptd_lane_type  lane0_ff [FW];
   ptd_lane_type  lane1_ff [FW];
   ptd_lane_type  lane0_in [FW];
   ptd_lane_type  lane1_in [FW];
   ptd_side_type  side_ff  [FW];
   ptd_side_type  side_in  [FW];

   for (genvar k = 0; k < FW; k++) begin : g_step
      if (k == FW - 1) begin : g_last
         assign adv[k] = !valid_ff[k] || out_ready;
      end else begin : g_mid
         assign adv[k] = !valid_ff[k] || adv[k+1];
      end

      if (k == 0) begin : g_first
         assign valid_in[k] = in_valid;
         assign lane0_in[k] = ptd_div_step(in_lane0);
         assign lane1_in[k] = ptd_div_step(in_lane1);
         assign side_in[k]  = in_side;
      end else begin : g_next
         assign valid_in[k] = valid_ff[k-1];
         assign lane0_in[k] = ptd_div_step(lane0_ff[k-1]);
         assign lane1_in[k] = ptd_div_step(lane1_ff[k-1]);
         assign side_in[k]  = side_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            valid_ff[k] <= valid_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            lane0_ff[k] <= lane0_in[k];
            lane1_ff[k] <= lane1_in[k];
            side_ff[k]  <= side_in[k];
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[FW-1];
   assign out_q0    = ptd_div_result(lane0_ff[FW-1]);
   assign out_q1    = ptd_div_result(lane1_ff[FW-1]);
   assign out_side  = side_ff[FW-1];

endmodule

// ----- design/point_triangle_distance.sv -----
// Top level of the point-to-triangle squared distance block with barycentric weights.
// Depends on ptd_pkg, the channel interfaces in ptd_if and the divider ptd_qdiv.
//
// The block takes one query beat per clock while no stage stalls, and returns one result beat
// per query, in order: six front stages form the differences, dot products, determinant, region
// split and divider operands, the two 16-stage divider lanes produce the Q.16 parameters one
// bit per stage, and four back stages evaluate the distance.
// Every stage holds a valid bit and moves as soon as the stage ahead of it is free, so bubbles
// close up and the query side keeps taking beats while a finished result waits on the output.

module point_triangle_distance import ptd_pkg::*; (
   input logic       clock,
   input logic       reset,
   ptd_req_if.sink   req_bus,
   ptd_rsp_if.source rsp_bus
);

   typedef struct packed {
      logic signed [EW-1:0] dx;
      logic signed [EW-1:0] dy;
      logic signed [EW-1:0] dz;
      logic signed [EW-1:0] ax;
      logic signed [EW-1:0] ay;
      logic signed [EW-1:0] az;
      logic signed [EW-1:0] bx;
      logic signed [EW-1:0] by;
      logic signed [EW-1:0] bz;
   } ptd_s1_type;

   typedef struct packed {
      ptd_dots_type         dots;
      logic signed [MW-1:0] ac;
      logic signed [MW-1:0] bb;
      logic signed [MW-1:0] be;
      logic signed [MW-1:0] cd;
      logic signed [MW-1:0] bd;
      logic signed [MW-1:0] ae;
   } ptd_s3_type;

   typedef struct packed {
      ptd_dots_type         dots;
      logic signed [SW-1:0] det;
      logic signed [SW-1:0] s;
      logic signed [SW-1:0] t;
   } ptd_s4_type;

   typedef struct packed {
      ptd_side_type         side;
      logic signed [XW-1:0] num0;
      logic signed [XW-1:0] den0;
      logic signed [XW-1:0] num1;
      logic signed [XW-1:0] den1;
   } ptd_s5_type;

   typedef struct packed {
      ptd_side_type side;
      ptd_lane_type lane0;
      ptd_lane_type lane1;
   } ptd_s6_type;

   typedef struct packed {
      ptd_kind_type         kind;
      ptd_dots_type         dots;
      logic [QW-1:0]        sq;
      logic [QW-1:0]        tq;
      logic signed [BW-1:0] asq;
      logic signed [BW-1:0] btq;
      logic signed [BW-1:0] bsq;
      logic signed [BW-1:0] ctq;
      logic signed [BW-1:0] dsq;
      logic signed [BW-1:0] etq;
   } ptd_b1_type;

   typedef struct packed {
      ptd_kind_type         kind;
      logic [QW-1:0]        sq;
      logic [QW-1:0]        tq;
      logic [QW-1:0]        w0;
      logic signed [UW-1:0] u;
      logic signed [UW-1:0] v;
      logic signed [LW-1:0] f32;
      logic signed [LW-1:0] vdist;
   } ptd_b2_type;

   typedef struct packed {
      ptd_kind_type         kind;
      logic [QW-1:0]        sq;
      logic [QW-1:0]        tq;
      logic [QW-1:0]        w0;
      logic signed [LW-1:0] su;
      logic signed [LW-1:0] tv;
      logic signed [LW-1:0] f32;
      logic signed [LW-1:0] vdist;
   } ptd_b3_type;

   typedef struct packed {
      logic [DISTW-1:0] dsq;
      logic [QW-1:0]    w0;
      logic [QW-1:0]    sq;
      logic [QW-1:0]    tq;
   } ptd_b4_type;

   function automatic ptd_lane_type ptd_lane_prep(input logic signed [XW-1:0] num,
                                                  input logic signed [XW-1:0] den);
      ptd_lane_type res;
      res.zero = (den <= 0) || (num <= 0);
      res.one  = !res.zero && (num >= den);
      res.den  = den[DIVW-1:0];
      res.rem  = num[DIVW-1:0];
      res.quo  = '0;
      return res;
   endfunction

   logic [5:0]   vf_ff;
   logic [5:0]   vf_in;
   logic [5:0]   adv_f;
   logic [3:0]   vb_ff;
   logic [3:0]   vb_in;
   logic [3:0]   adv_b;

   ptd_s1_type   s1_ff, s1_in;
   ptd_dots_type s2_ff, s2_in;
   ptd_s3_type   s3_ff, s3_in;
   ptd_s4_type   s4_ff, s4_in;
   ptd_s5_type   s5_ff, s5_in;
   ptd_s6_type   s6_ff, s6_in;
   ptd_b1_type   b1_ff, b1_in;
   ptd_b2_type   b2_ff, b2_in;
   ptd_b3_type   b3_ff, b3_in;
   ptd_b4_type   b4_ff, b4_in;

   logic          div_in_ready;
   logic          div_out_valid;
   logic [QW-1:0] div_q0;
   logic [QW-1:0] div_q1;
   ptd_side_type  div_side;

   // Stage handshakes: a stage loads when it is empty or the stage ahead moves.
   always_comb begin
      adv_f[5] = !vf_ff[5] || div_in_ready;
      for (int k = 4; k >= 0; k--) begin
         adv_f[k] = !vf_ff[k] || adv_f[k+1];
      end
      adv_b[3] = !vb_ff[3] || rsp_bus.ready;
      for (int k = 2; k >= 0; k--) begin
         adv_b[k] = !vb_ff[k] || adv_b[k+1];
      end
   end

   assign vf_in = {vf_ff[4:0], req_bus.valid};
   assign vb_in = {vb_ff[2:0], div_out_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= '0;
         vb_ff <= '0;
      end else begin
         for (int k = 0; k < 6; k++) begin
            if (adv_f[k]) begin
               vf_ff[k] <= vf_in[k];
            end
         end
         for (int k = 0; k < 4; k++) begin
            if (adv_b[k]) begin
               vb_ff[k] <= vb_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_f[0]) begin
         s1_ff <= s1_in;
      end
      if (adv_f[1]) begin
         s2_ff <= s2_in;
      end
      if (adv_f[2]) begin
         s3_ff <= s3_in;
      end
      if (adv_f[3]) begin
         s4_ff <= s4_in;
      end
      if (adv_f[4]) begin
         s5_ff <= s5_in;
      end
      if (adv_f[5]) begin
         s6_ff <= s6_in;
      end
      if (adv_b[0]) begin
         b1_ff <= b1_in;
      end
      if (adv_b[1]) begin
         b2_ff <= b2_in;
      end
      if (adv_b[2]) begin
         b3_ff <= b3_in;
      end
      if (adv_b[3]) begin
         b4_ff <= b4_in;
      end
   end

   always_comb begin
      s1_in.dx = EW'(req_bus.corner_x) - EW'(req_bus.point_x);
      s1_in.dy = EW'(req_bus.corner_y) - EW'(req_bus.point_y);
      s1_in.dz = EW'(req_bus.corner_z) - EW'(req_bus.point_z);
      s1_in.ax = req_bus.edge_a_x;
      s1_in.ay = req_bus.edge_a_y;
      s1_in.az = req_bus.edge_a_z;
      s1_in.bx = req_bus.edge_b_x;
      s1_in.by = req_bus.edge_b_y;
      s1_in.bz = req_bus.edge_b_z;
   end

   always_comb begin
      s2_in.a = PW'(s1_ff.ax) * PW'(s1_ff.ax) + PW'(s1_ff.ay) * PW'(s1_ff.ay)
              + PW'(s1_ff.az) * PW'(s1_ff.az);
      s2_in.b = PW'(s1_ff.ax) * PW'(s1_ff.bx) + PW'(s1_ff.ay) * PW'(s1_ff.by)
              + PW'(s1_ff.az) * PW'(s1_ff.bz);
      s2_in.c = PW'(s1_ff.bx) * PW'(s1_ff.bx) + PW'(s1_ff.by) * PW'(s1_ff.by)
              + PW'(s1_ff.bz) * PW'(s1_ff.bz);
      s2_in.d = PW'(s1_ff.ax) * PW'(s1_ff.dx) + PW'(s1_ff.ay) * PW'(s1_ff.dy)
              + PW'(s1_ff.az) * PW'(s1_ff.dz);
      s2_in.e = PW'(s1_ff.bx) * PW'(s1_ff.dx) + PW'(s1_ff.by) * PW'(s1_ff.dy)
              + PW'(s1_ff.bz) * PW'(s1_ff.dz);
      s2_in.f = PW'(s1_ff.dx) * PW'(s1_ff.dx) + PW'(s1_ff.dy) * PW'(s1_ff.dy)
              + PW'(s1_ff.dz) * PW'(s1_ff.dz);
   end

   always_comb begin
      s3_in.dots = s2_ff;
      s3_in.ac   = MW'(s2_ff.a) * MW'(s2_ff.c);
      s3_in.bb   = MW'(s2_ff.b) * MW'(s2_ff.b);
      s3_in.be   = MW'(s2_ff.b) * MW'(s2_ff.e);
      s3_in.cd   = MW'(s2_ff.c) * MW'(s2_ff.d);
      s3_in.bd   = MW'(s2_ff.b) * MW'(s2_ff.d);
      s3_in.ae   = MW'(s2_ff.a) * MW'(s2_ff.e);
   end

   always_comb begin
      s4_in.dots = s3_ff.dots;
      s4_in.det  = SW'(s3_ff.ac) - SW'(s3_ff.bb);
      s4_in.s    = SW'(s3_ff.be) - SW'(s3_ff.cd);
      s4_in.t    = SW'(s3_ff.bd) - SW'(s3_ff.ae);
   end

   // Region split of the unconstrained minimum in the (s, t) plane.
   always_comb begin
      logic signed [XW-1:0] ca;
      logic signed [XW-1:0] cb;
      logic signed [XW-1:0] cc;
      logic signed [XW-1:0] cd;
      logic signed [XW-1:0] ce;
      logic signed [XW-1:0] cdet;
      logic signed [XW-1:0] cs;
      logic signed [XW-1:0] ct;
      logic signed [XW-1:0] cden;
      logic signed [XW-1:0] nu_s;
      logic signed [XW-1:0] nu_t;
      logic signed [XW-1:0] nu_r;
      ca   = XW'(s4_ff.dots.a);
      cb   = XW'(s4_ff.dots.b);
      cc   = XW'(s4_ff.dots.c);
      cd   = XW'(s4_ff.dots.d);
      ce   = XW'(s4_ff.dots.e);
      cdet = XW'(s4_ff.det);
      cs   = XW'(s4_ff.s);
      ct   = XW'(s4_ff.t);
      cden = ca - (cb <<< 1) + cc;
      nu_s = (cc + ce) - (cb + cd);
      nu_t = (ca + cd) - (cb + ce);
      nu_r = cc + ce - cb - cd;
      s5_in.side.dots = s4_ff.dots;
      s5_in.side.kind = KIND_V0;
      s5_in.num0      = '0;
      s5_in.den0      = '0;
      s5_in.num1      = '0;
      s5_in.den1      = '0;
      if (cs + ct <= cdet) begin
         if (cs < 0 && ct < 0 && cd < 0) begin
            if (-cd >= ca) begin
               s5_in.side.kind = KIND_V1;
            end else begin
               s5_in.side.kind = KIND_EA;
               s5_in.num0      = -cd;
               s5_in.den0      = ca;
            end
         end else if (cs < 0) begin
            if (ce >= 0) begin
               s5_in.side.kind = KIND_V0;
            end else if (-ce >= cc) begin
               s5_in.side.kind = KIND_V2;
            end else begin
               s5_in.side.kind = KIND_EB;
               s5_in.num0      = -ce;
               s5_in.den0      = cc;
            end
         end else if (ct < 0) begin
            if (cd >= 0) begin
               s5_in.side.kind = KIND_V0;
            end else if (-cd >= ca) begin
               s5_in.side.kind = KIND_V1;
            end else begin
               s5_in.side.kind = KIND_EA;
               s5_in.num0      = -cd;
               s5_in.den0      = ca;
            end
         end else begin
            s5_in.side.kind = KIND_IN;
            s5_in.num0      = cs;
            s5_in.den0      = cdet;
            s5_in.num1      = ct;
            s5_in.den1      = cdet;
         end
      end else if (cs < 0) begin
         if (cc + ce > cb + cd) begin
            if (nu_s >= cden) begin
               s5_in.side.kind = KIND_V1;
            end else begin
               s5_in.side.kind = KIND_SA;
               s5_in.num0      = nu_s;
               s5_in.den0      = cden;
            end
         end else if (cc + ce <= 0) begin
            s5_in.side.kind = KIND_V2;
         end else if (ce >= 0) begin
            s5_in.side.kind = KIND_V0;
         end else begin
            s5_in.side.kind = KIND_EB;
            s5_in.num0      = -ce;
            s5_in.den0      = cc;
         end
      end else if (ct < 0) begin
         if (ca + cd > cb + ce) begin
            if (nu_t >= cden) begin
               s5_in.side.kind = KIND_V2;
            end else begin
               s5_in.side.kind = KIND_TB;
               s5_in.num0      = nu_t;
               s5_in.den0      = cden;
            end
         end else if (ca + cd <= 0) begin
            s5_in.side.kind = KIND_V1;
         end else if (cd >= 0) begin
            s5_in.side.kind = KIND_V0;
         end else begin
            s5_in.side.kind = KIND_EA;
            s5_in.num0      = -cd;
            s5_in.den0      = ca;
         end
      end else begin
         if (nu_r <= 0) begin
            s5_in.side.kind = KIND_V2;
         end else if (nu_r >= cden) begin
            s5_in.side.kind = KIND_V1;
         end else begin
            s5_in.side.kind = KIND_SA;
            s5_in.num0      = nu_r;
            s5_in.den0      = cden;
         end
      end
   end

   always_comb begin
      s6_in.side  = s5_ff.side;
      s6_in.lane0 = ptd_lane_prep(s5_ff.num0, s5_ff.den0);
      s6_in.lane1 = ptd_lane_prep(s5_ff.num1, s5_ff.den1);
   end

   ptd_qdiv u_qdiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vf_ff[5]),
      .in_ready  (div_in_ready),
      .in_lane0  (s6_ff.lane0),
      .in_lane1  (s6_ff.lane1),
      .in_side   (s6_ff.side),
      .out_valid (div_out_valid),
      .out_ready (adv_b[0]),
      .out_q0    (div_q0),
      .out_q1    (div_q1),
      .out_side  (div_side)
   );

   always_comb begin
      logic [QW-1:0]      sq;
      logic [QW-1:0]      tq;
      logic signed [QW:0] sq_s;
      logic signed [QW:0] tq_s;
      unique case (div_side.kind)
         KIND_V0: begin
            sq = '0;
            tq = '0;
         end
         KIND_V1: begin
            sq = QONE;
            tq = '0;
         end
         KIND_V2: begin
            sq = '0;
            tq = QONE;
         end
         KIND_EA: begin
            sq = div_q0;
            tq = '0;
         end
         KIND_EB: begin
            sq = '0;
            tq = div_q0;
         end
         KIND_IN: begin
            sq = div_q0;
            tq = div_q1;
         end
         KIND_SA: begin
            sq = div_q0;
            tq = QONE - div_q0;
         end
         KIND_TB: begin
            sq = QONE - div_q0;
            tq = div_q0;
         end
         default: begin
            sq = '0;
            tq = '0;
         end
      endcase
      sq_s        = $signed({1'b0, sq});
      tq_s        = $signed({1'b0, tq});
      b1_in.kind  = div_side.kind;
      b1_in.dots  = div_side.dots;
      b1_in.sq    = sq;
      b1_in.tq    = tq;
      b1_in.asq   = BW'(div_side.dots.a) * BW'(sq_s);
      b1_in.btq   = BW'(div_side.dots.b) * BW'(tq_s);
      b1_in.bsq   = BW'(div_side.dots.b) * BW'(sq_s);
      b1_in.ctq   = BW'(div_side.dots.c) * BW'(tq_s);
      b1_in.dsq   = BW'(div_side.dots.d) * BW'(sq_s);
      b1_in.etq   = BW'(div_side.dots.e) * BW'(tq_s);
   end

   always_comb begin
      logic [QW:0]          wsum;
      logic signed [LW-1:0] la;
      logic signed [LW-1:0] lc;
      logic signed [LW-1:0] ld;
      logic signed [LW-1:0] le;
      logic signed [LW-1:0] lf;
      wsum = {1'b0, b1_ff.sq} + {1'b0, b1_ff.tq};
      la   = LW'(b1_ff.dots.a);
      lc   = LW'(b1_ff.dots.c);
      ld   = LW'(b1_ff.dots.d);
      le   = LW'(b1_ff.dots.e);
      lf   = LW'(b1_ff.dots.f);
      b2_in.kind = b1_ff.kind;
      b2_in.sq   = b1_ff.sq;
      b2_in.tq   = b1_ff.tq;
      b2_in.w0   = (wsum > {1'b0, QONE}) ? '0 : QW'({1'b0, QONE} - wsum);
      b2_in.u    = UW'(b1_ff.asq) + UW'(b1_ff.btq) + (UW'(b1_ff.dots.d) <<< (FW + 1));
      b2_in.v    = UW'(b1_ff.bsq) + UW'(b1_ff.ctq) + (UW'(b1_ff.dots.e) <<< (FW + 1));
      b2_in.f32  = lf <<< (2 * FW);
      unique case (b1_ff.kind)
         KIND_V1: b2_in.vdist = (la + (ld <<< 1) + lf) <<< FW;
         KIND_V2: b2_in.vdist = (lc + (le <<< 1) + lf) <<< FW;
         KIND_EA: b2_in.vdist = LW'(b1_ff.dsq) + (lf <<< FW);
         KIND_EB: b2_in.vdist = LW'(b1_ff.etq) + (lf <<< FW);
         default: b2_in.vdist = lf <<< FW;
      endcase
   end

   always_comb begin
      b3_in.kind  = b2_ff.kind;
      b3_in.sq    = b2_ff.sq;
      b3_in.tq    = b2_ff.tq;
      b3_in.w0    = b2_ff.w0;
      b3_in.su    = LW'($signed({1'b0, b2_ff.sq})) * LW'(b2_ff.u);
      b3_in.tv    = LW'($signed({1'b0, b2_ff.tq})) * LW'(b2_ff.v);
      b3_in.f32   = b2_ff.f32;
      b3_in.vdist = b2_ff.vdist;
   end

   always_comb begin
      logic signed [LW-1:0] q32;
      logic signed [LW-1:0] dval;
      q32 = b3_ff.su + b3_ff.tv + b3_ff.f32;
      if (b3_ff.kind == KIND_IN || b3_ff.kind == KIND_SA || b3_ff.kind == KIND_TB) begin
         dval = (q32 < 0) ? '0 : (q32 >>> FW);
      end else begin
         dval = b3_ff.vdist;
      end
      if (dval < 0) begin
         b4_in.dsq = '0;
      end else if (dval > LW'(DIST_MAX)) begin
         b4_in.dsq = DIST_MAX;
      end else begin
         b4_in.dsq = dval[DISTW-1:0];
      end
      b4_in.w0 = b3_ff.w0;
      b4_in.sq = b3_ff.sq;
      b4_in.tq = b3_ff.tq;
   end

   assign req_bus.ready         = adv_f[0];
   assign rsp_bus.valid         = vb_ff[3];
   assign rsp_bus.dist_sq       = b4_ff.dsq;
   assign rsp_bus.weight_first  = b4_ff.w0;
   assign rsp_bus.weight_second = b4_ff.sq;
   assign rsp_bus.weight_third  = b4_ff.tq;

endmodule
